// File: src/assert_macros.svh
// Assertion macros used by the converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is high.
`define E2Q_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define E2Q_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: src/e2q_pkg.sv
// Types and constants of the Euler angle to quaternion converter.
package e2q_pkg;
   localparam int FIELD_W = 16;                  // width of every angle and quaternion field
   localparam int CW      = 34;                  // CORDIC datapath width, Q2.30 plus headroom
   localparam int PW      = 2 * CW;              // full product width
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [22:0] Q14_MAX = 23'sd16384;
   localparam logic signed [22:0] Q14_MIN = -23'sd16384;

   typedef logic signed [CW-1:0] cval_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Arctangent of 2^-i in Q2.30
   function automatic cval_type atan_step(input int i);
      cval_type r;
      case (i)
         0:  r = 34'sd843314857;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043837;
         3:  r = 34'sd133525159;
         4:  r = 34'sd67021687;
         5:  r = 34'sd33543516;
         6:  r = 34'sd16775851;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194283;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048576;
         default: begin
            if (i <= 30) r = cval_type'(34'sd1 <<< (30 - i));
            else r = '0;
         end
      endcase
      return r;
   endfunction
endpackage

// File: src/e2q_front.sv
// Front end: takes angle beats and turns each angle into a half angle in radians.
module e2q_front #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [3*e2q_pkg::FIELD_W-1:0] req_tdata,   // roll, pitch, yaw
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [3*e2q_pkg::CW-1:0]      out_z        // roll, pitch, yaw half angles
);
   import e2q_pkg::*;

   localparam int MW = ANGLE_BITS + 32;

   logic                  vld_ff, vld_in;
   logic [3*CW-1:0]       z_ff;
   logic [3*CW-1:0]       z_in;
   logic                  accept;

   assign req_tready = !vld_ff || out_ready;
   assign accept     = req_tvalid && req_tready;

   // Half angle: |a| * pi >> ANGLE_BITS with rounding, then sign
   always_comb begin
      logic [ANGLE_BITS-1:0] u, mag;
      logic [MW-1:0]         prod;
      logic [31:0]           r;
      z_in = '0;
      for (int k = 0; k < 3; k++) begin
         u    = ANGLE_BITS'(req_tdata[k*FIELD_W +: FIELD_W]);
         mag  = u[ANGLE_BITS-1] ? (~u + 1'b1) : u;
         prod = MW'(mag) * MW'(PI_Q30) + (MW'(1) << (ANGLE_BITS - 1));
         r    = prod[MW-1:ANGLE_BITS];
         z_in[k*CW +: CW] = u[ANGLE_BITS-1] ? (~CW'(r) + 1'b1) : CW'(r);
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (accept) vld_in = 1'b1;
      else if (out_ready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) z_ff <= z_in;
   end

   assign out_valid = vld_ff;
   assign out_z     = z_ff;
endmodule

// File: src/e2q_queue.sv
// Two-entry queue between the front end and the CORDIC back end.
module e2q_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [3*e2q_pkg::CW-1:0] in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [3*e2q_pkg::CW-1:0] out_data,
   output e2q_pkg::q_stat_type      stat
);
   import e2q_pkg::*;

   logic [3*CW-1:0] data_ff [2];
   logic            wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push, pop;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign in_ready   = !stat.full;
   assign out_valid  = !stat.empty;
   assign push       = in_valid && in_ready;
   assign pop        = out_ready && out_valid;
   assign out_data   = data_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ff] <= in_data;
   end
endmodule

// File: src/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine of one angle, one step per stage.
module e2q_cordic #(
   parameter int STEPS = 16
) (
   input  logic              clock,
   input  logic              en,
   input  e2q_pkg::cval_type z_in,
   output e2q_pkg::cval_type cos_out,
   output e2q_pkg::cval_type sin_out
);
   import e2q_pkg::*;

   cval_type x_ff [STEPS];
   cval_type y_ff [STEPS];
   cval_type z_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      cval_type xs, ys, zs;
      if (i == 0) begin : g_seed
         assign xs = GAIN_Q30;
         assign ys = '0;
         assign zs = z_in;
      end else begin : g_chain
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end
      // Rotate toward zero residual angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (!zs[CW-1]) begin
               x_ff[i] <= xs - (ys >>> i);
               y_ff[i] <= ys + (xs >>> i);
               z_ff[i] <= zs - atan_step(i);
            end else begin
               x_ff[i] <= xs + (ys >>> i);
               y_ff[i] <= ys - (xs >>> i);
               z_ff[i] <= zs + atan_step(i);
            end
         end
      end
   end

   assign cos_out = x_ff[STEPS-1];
   assign sin_out = y_ff[STEPS-1];
endmodule

// File: src/e2q_back.sv
// Back end: three CORDIC lanes, pair and triple products, rounding and output register.
module e2q_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [3*e2q_pkg::CW-1:0]     in_z,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [4*e2q_pkg::FIELD_W-1:0] rsp_tdata
);
   import e2q_pkg::*;

   localparam int NV = CORDIC_STEPS + 2;

   logic           en;
   logic [NV-1:0]  vld_ff;
   logic           out_vld_ff;
   cval_type       c_r, s_r, c_p, s_p, c_y, s_y;
   cval_type       cc_ff, ss_ff, sc_ff, cs_ff, cy_ff, sy_ff;
   logic signed [PW-1:0] t_ff [8];
   logic [4*FIELD_W-1:0] q_ff, q_in;

   // Whole pipeline advances unless the output beat is stuck
   assign en       = !out_vld_ff || rsp_tready;
   assign in_ready = en;

   e2q_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .en(en), .z_in(in_z[0 +: CW]), .cos_out(c_r), .sin_out(s_r));
   e2q_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .en(en), .z_in(in_z[CW +: CW]), .cos_out(c_p), .sin_out(s_p));
   e2q_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock(clock), .en(en), .z_in(in_z[2*CW +: CW]), .cos_out(c_y), .sin_out(s_y));

   // Roll-pitch pair products rounded back to Q30
   function automatic cval_type pair(input cval_type a, input cval_type b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
      return p[CW+29:30];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff <= pair(c_r, c_p);
         ss_ff <= pair(s_r, s_p);
         sc_ff <= pair(s_r, c_p);
         cs_ff <= pair(c_r, s_p);
         cy_ff <= c_y;
         sy_ff <= s_y;
      end
   end

   // Triple products in Q60
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= cc_ff * cy_ff;
         t_ff[1] <= ss_ff * sy_ff;
         t_ff[2] <= sc_ff * cy_ff;
         t_ff[3] <= cs_ff * sy_ff;
         t_ff[4] <= cs_ff * cy_ff;
         t_ff[5] <= sc_ff * sy_ff;
         t_ff[6] <= cc_ff * sy_ff;
         t_ff[7] <= ss_ff * cy_ff;
      end
   end

   // Sum, round to Q1.14, saturate
   function automatic logic [FIELD_W-1:0] to_q14(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b,
                                                 input logic sub);
      logic signed [PW:0]  s;
      logic signed [22:0]  v;
      s = sub ? ((PW+1)'(a) - (PW+1)'(b)) : ((PW+1)'(a) + (PW+1)'(b));
      s = s + ((PW+1)'(1) <<< 45);
      v = s[PW:46];
      if (v > Q14_MAX) v = Q14_MAX;
      if (v < Q14_MIN) v = Q14_MIN;
      return v[FIELD_W-1:0];
   endfunction

   always_comb begin
      q_in[0*FIELD_W +: FIELD_W] = to_q14(t_ff[0], t_ff[1], 1'b0);
      q_in[1*FIELD_W +: FIELD_W] = to_q14(t_ff[2], t_ff[3], 1'b1);
      q_in[2*FIELD_W +: FIELD_W] = to_q14(t_ff[4], t_ff[5], 1'b0);
      q_in[3*FIELD_W +: FIELD_W] = to_q14(t_ff[6], t_ff[7], 1'b1);
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   // Valid chain follows the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[NV-2:0], in_valid};
         out_vld_ff <= vld_ff[NV-1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = q_ff;
endmodule

// File: src/euler_to_quaternion_core.sv
// Converter from roll, pitch, yaw binary angles to a ZYX quaternion in Q1.14.
//
// Input channel req_*: one beat carries roll, pitch and yaw (signed, 16 bits,
// 32768 is pi). Result channel rsp_*: one beat per input beat carries w, x, y, z
// (signed Q1.14, 16384 is 1.0), in input order.
// From an accepted input beat to its result beat when nothing stalls: half angle
// registered at the accepting edge, then queue stage, CORDIC_STEPS CORDIC stages,
// pair products, triple products, rounding into the output register.
// Throughput: one beat per cycle while nothing stalls; the CORDIC pipeline holds one item per stage.
// A two-entry queue sits between the half angle front end and the back end,
// so input beats keep being taken for a while after the result side stalls.
// When rsp_tready is low with a result waiting, the back end holds in place;
// the queue then fills and req_tready drops.
// Reset clears all valid state; no result beat follows reset until new input.
module euler_to_quaternion_core #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [3*e2q_pkg::FIELD_W-1:0] req_tdata,  // roll_angle, pitch_angle, yaw_angle
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [4*e2q_pkg::FIELD_W-1:0] rsp_tdata   // quat_w, quat_x, quat_y, quat_z
);
   import e2q_pkg::*;
   `include "assert_macros.svh"

   logic            f_valid, f_ready, q_valid, q_ready;
   logic [3*CW-1:0] f_z, q_z;
   q_stat_type      q_stat;

   e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .out_valid(f_valid), .out_ready(f_ready), .out_z(f_z));

   e2q_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_z),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_z),
      .stat(q_stat));

   e2q_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_z(q_z),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   `E2Q_ASSERT(a_queue_stat, clock, reset, !(q_stat.full && q_stat.empty), "queue full and empty")
   `E2Q_ASSERT(a_w_range, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384 && $signed(rsp_tdata[15:0]) >= -16'sd16384), "quat_w out of range")
   `E2Q_ASSERT(a_x_range, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[31:16]) <= 16'sd16384 && $signed(rsp_tdata[31:16]) >= -16'sd16384), "quat_x out of range")
endmodule
